FILE: rtl/core/pfer_pkg.sv
`default_nettype none

package pfer_pkg;

   // Source format codes held in the mode register.
   localparam logic [1:0] MODE_MONO = 2'd0;
   localparam logic [1:0] MODE_GREY = 2'd1;
   localparam logic [1:0] MODE_PASS = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_COLOR_MODE       = 2'd0;
   localparam logic [1:0] CSR_BACKGROUND_COLOR = 2'd1;
   localparam logic [1:0] CSR_FOREGROUND_COLOR = 2'd2;

   // Work kinds handed from the front part to the back part.
   localparam logic [1:0] KIND_MONO = 2'd0;
   localparam logic [1:0] KIND_GREY = 2'd1;
   localparam logic [1:0] KIND_PASS = 2'd2;

   // Index of the final output byte for each kind.
   localparam logic [3:0] MONO_LAST_STEP = 4'd15;
   localparam logic [3:0] GREY_LAST_STEP = 4'd3;
   localparam logic [3:0] PASS_LAST_STEP = 4'd0;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       image_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       image_last;
   } rsp_type;

   // One classified request waiting for expansion.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] pixel_byte;
      logic       image_end;
   } cmd_type;

   // Colours used by the back part in mono mode.
   typedef struct packed {
      logic [15:0] background_color;
      logic [15:0] foreground_color;
   } colour_type;

   // High byte of a grey pixel: red is the nibble with its low bit repeated.
   function automatic logic [7:0] grey_high(input logic [3:0] n);
      grey_high = {n, n[0], n[3:1]};
   endfunction

   // Low byte of a grey pixel: the tail of green, then blue.
   function automatic logic [7:0] grey_low(input logic [3:0] n);
      grey_low = {n[0], n[0], n[0], n, n[0]};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pixel_format_expander_rgb565.sv
// RGB565 pixel format expander.
// Requests enter through a queue-style port: a source byte and an end-of-image
// flag are taken at each clock edge where req_push is high and req_full is low.
// Results leave the same way: the oldest output byte is on rsp_data while
// rsp_empty is low and is taken when rsp_pop is high.
// Mono mode gives 16 bytes per request, grey mode 4 and passthrough 1; the
// expander sends one byte per cycle while the receiver keeps up, and a new
// request follows its predecessor without a gap when one is waiting.
// When the block is otherwise empty, an accepted request passes the request
// queue and the expander's command register before its first byte appears.
// Up to QUEUE_DEPTH classified requests wait ahead of the expander, so the
// source is held off only when that queue is full.
// When the receiver stalls, the output register holds its byte and the
// expander and then the queue fill up, after which req_full is raised.
// Reset empties the queue and the output, sets the mode to mono, the
// background to black and the foreground to white. Configuration is written
// via csr_write/csr_index/csr_data, by the user only while idle (unchecked).
`default_nettype none

module pixel_format_expander_rgb565 #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire pfer_pkg::req_type   req_data,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output pfer_pkg::rsp_type        rsp_data,
   input  wire logic                csr_write,
   input  wire logic [1:0]          csr_index,
   input  wire logic [15:0]         csr_data
);

   logic                 queue_push;
   pfer_pkg::cmd_type    queue_in_data;
   logic                 queue_full;
   logic                 queue_pop;
   pfer_pkg::cmd_type    queue_out_data;
   logic                 queue_empty;
   pfer_pkg::colour_type colours;

   // Front part: registers and request classification.
   pfer_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_push   (req_push),
      .req_data   (req_data),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_data (queue_in_data),
      .colours    (colours)
   );

   // Queue between classification and expansion.
   pfer_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_in_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (queue_out_data),
      .empty     (queue_empty)
   );

   // Back part: byte sequencing and the output register.
   pfer_back u_back (
      .clock       (clock),
      .reset       (reset),
      .colours     (colours),
      .queue_empty (queue_empty),
      .queue_data  (queue_out_data),
      .queue_pop   (queue_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

   assign req_full = queue_full;

endmodule

`default_nettype wire

FILE: rtl/core/pfer_front.sv
`default_nettype none

module pfer_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire logic [1:0]           csr_index,
   input  wire logic [15:0]          csr_data,
   input  wire logic                 req_push,
   input  wire pfer_pkg::req_type    req_data,
   input  wire logic                 queue_full,
   output logic                      queue_push,
   output pfer_pkg::cmd_type         queue_data,
   output pfer_pkg::colour_type      colours
);

   logic [1:0]  color_mode_ff;
   logic [1:0]  color_mode_in;
   logic [15:0] background_ff;
   logic [15:0] background_in;
   logic [15:0] foreground_ff;
   logic [15:0] foreground_in;

   // Register writes; an index beyond the list is ignored.
   always_comb begin
      color_mode_in = color_mode_ff;
      background_in = background_ff;
      foreground_in = foreground_ff;
      if (csr_write) begin
         unique case (csr_index)
            pfer_pkg::CSR_COLOR_MODE:       color_mode_in = csr_data[1:0];
            pfer_pkg::CSR_BACKGROUND_COLOR: background_in = csr_data;
            pfer_pkg::CSR_FOREGROUND_COLOR: foreground_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= pfer_pkg::MODE_MONO;
         background_ff <= 16'h0000;
         foreground_ff <= 16'hFFFF;
      end else begin
         color_mode_ff <= color_mode_in;
         background_ff <= background_in;
         foreground_ff <= foreground_in;
      end
   end

   // Classify the request by the current mode; the unused mode code passes through.
   always_comb begin
      queue_push            = req_push && !queue_full;
      queue_data.pixel_byte = req_data.pixel_byte;
      queue_data.image_end  = req_data.image_end;
      unique case (color_mode_ff)
         pfer_pkg::MODE_MONO: queue_data.kind = pfer_pkg::KIND_MONO;
         pfer_pkg::MODE_GREY: queue_data.kind = pfer_pkg::KIND_GREY;
         default:             queue_data.kind = pfer_pkg::KIND_PASS;
      endcase
   end

   assign colours.background_color = background_ff;
   assign colours.foreground_color = foreground_ff;

endmodule

`default_nettype wire

FILE: rtl/core/pfer_queue.sv
`default_nettype none

module pfer_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire pfer_pkg::cmd_type   push_data,
   output logic                     full,
   input  wire logic                pop,
   output pfer_pkg::cmd_type        pop_data,
   output logic                     empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   pfer_pkg::cmd_type entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff;
   logic [PW-1:0] rd_ptr_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          do_push;
   logic          do_pop;

   // Pointer and fill count bookkeeping, wrapping at the depth.
   always_comb begin
      full    = (count_ff == CW'(DEPTH));
      empty   = (count_ff == '0);
      do_push = push && !full;
      do_pop  = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage for waiting requests.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = entries_ff[rd_ptr_ff];

endmodule

`default_nettype wire

FILE: rtl/core/pfer_back.sv
`default_nettype none

module pfer_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pfer_pkg::colour_type  colours,
   input  wire logic                  queue_empty,
   input  wire pfer_pkg::cmd_type     queue_data,
   output logic                       queue_pop,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output pfer_pkg::rsp_type          rsp_data
);

   pfer_pkg::cmd_type cmd_ff;
   pfer_pkg::cmd_type cmd_in;
   logic              busy_ff;
   logic              busy_in;
   logic [3:0]        step_ff;
   logic [3:0]        step_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   pfer_pkg::rsp_type out_ff;
   pfer_pkg::rsp_type out_in;

   logic        advance;
   logic        is_last;
   logic        load;
   logic [3:0]  last_step;
   logic [7:0]  next_byte;
   logic [15:0] mono_colour;
   logic [3:0]  nibble;

   // Produce the byte for the current step of the current request.
   always_comb begin
      mono_colour = cmd_ff.pixel_byte[3'd7 - step_ff[3:1]] ?
                    colours.foreground_color : colours.background_color;
      nibble      = step_ff[1] ? cmd_ff.pixel_byte[3:0] : cmd_ff.pixel_byte[7:4];
      unique case (cmd_ff.kind)
         pfer_pkg::KIND_MONO: begin
            last_step = pfer_pkg::MONO_LAST_STEP;
            next_byte = step_ff[0] ? mono_colour[7:0] : mono_colour[15:8];
         end
         pfer_pkg::KIND_GREY: begin
            last_step = pfer_pkg::GREY_LAST_STEP;
            next_byte = step_ff[0] ? pfer_pkg::grey_low(nibble) : pfer_pkg::grey_high(nibble);
         end
         default: begin
            last_step = pfer_pkg::PASS_LAST_STEP;
            next_byte = cmd_ff.pixel_byte;
         end
      endcase
   end

   // Step sequencing; the next request is taken as the last byte goes out.
   always_comb begin
      advance   = busy_ff && (!out_valid_ff || rsp_pop);
      is_last   = (step_ff == last_step);
      load      = !busy_ff || (advance && is_last);
      queue_pop = load && !queue_empty;
      busy_in   = load ? !queue_empty : busy_ff;
      cmd_in    = queue_pop ? queue_data : cmd_ff;
      if (load) begin
         step_in = '0;
      end else if (advance) begin
         step_in = step_ff + 1'b1;
      end else begin
         step_in = step_ff;
      end
   end

   // Output register; holds its byte while the receiver stalls.
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_in.out_byte   = next_byte;
         out_in.run_last   = is_last;
         out_in.image_last = is_last && cmd_ff.image_end;
         out_valid_in      = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire
